@@ rtl/tpsw_pkg.sv @@
// Shared constants and types for the tree path step walker.
// No dependencies; used by the interfaces, the core and the bench files.
package tpsw_pkg;

   localparam int MAX_NODES   = 1024;
   localparam int LIFT_LEVELS = 10;
   localparam int NODE_W      = 10;
   localparam int DEPTH_W     = 10;
   localparam int STEPS_W     = 11;
   localparam int LVL_W       = (LIFT_LEVELS > 1) ? $clog2(LIFT_LEVELS) : 1;
   localparam int ANC_AW      = NODE_W + LVL_W;
   localparam int DIFF_W      = (LIFT_LEVELS > 12) ? LIFT_LEVELS + 1 : 13;

   localparam logic [DEPTH_W-1:0] DEPTH_MAX = {DEPTH_W{1'b1}};

   localparam logic ACT_ATTACH = 1'b0;
   localparam logic ACT_QUERY  = 1'b1;

   typedef logic [NODE_W-1:0]      node_type;
   typedef logic [DEPTH_W-1:0]     depth_type;
   typedef logic [LVL_W-1:0]       lvl_type;
   typedef logic [LIFT_LEVELS-1:0] dist_type;
   typedef logic signed [DIFF_W-1:0] diff_type;

endpackage

@@ rtl/tpsw_if.sv @@
// Handshake channels of the tree path step walker: request and response.
// Depends on tpsw_pkg.
interface tpsw_req_if;
   logic                         valid;
   logic                         ready;
   logic                         action;
   logic [tpsw_pkg::NODE_W-1:0]  node_a;
   logic [tpsw_pkg::NODE_W-1:0]  node_b;
   logic [tpsw_pkg::STEPS_W-1:0] steps;
   modport source (output valid, action, node_a, node_b, steps, input ready);
   modport sink   (input valid, action, node_a, node_b, steps, output ready);
endinterface

interface tpsw_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [tpsw_pkg::NODE_W-1:0] result_node;
   modport source (output valid, result_node, input ready);
   modport sink   (input valid, result_node, output ready);
endinterface

@@ rtl/tpsw_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module tpsw_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule

@@ rtl/tree_path_step_walker_core.sv @@
// Top level of the tree path step walker: sequencer over ancestor and depth RAMs.
// Depends on tpsw_pkg, tpsw_if and tpsw_ram.
//
// Use: req carries items. An attach item (action 0) adds node_a under parent
// node_b and fills its binary lifting row; node 1 is the root, attached
// under 0. Attach items must come parent first. A query item (action 1)
// returns on rsp the node reached by walking steps edges from node_a towards
// node_b, or node_b when the walk reaches or passes it. Attaches give no item.
// One item is worked on at a time; req.ready is high only between items.
// An attach fills the lifting row one level at a time. A query does a
// depth-matching jump, a common-ancestor search and a final jump, each
// stepping through the lifting levels.
// The result sits in an output register; the next item is taken while it
// waits, and a further result stalls in the sequencer until rsp.ready.
// Reset clears the sequencer and the output valid; the RAMs are not cleared
// and node 0 reads as the all-zero sentinel row.
module tree_path_step_walker_core (
   input logic       clock,
   input logic       reset,
   tpsw_req_if.sink   req_chan,
   tpsw_rsp_if.source rsp_chan
);
   localparam logic [4:0] S_IDLE   = 5'd0;
   localparam logic [4:0] S_AT_DEP = 5'd1;
   localparam logic [4:0] S_AT_DPW = 5'd2;
   localparam logic [4:0] S_AT_RD  = 5'd3;
   localparam logic [4:0] S_AT_WR  = 5'd4;
   localparam logic [4:0] S_Q_DA   = 5'd5;
   localparam logic [4:0] S_Q_DB   = 5'd6;
   localparam logic [4:0] S_Q_DBW  = 5'd7;
   localparam logic [4:0] S_Q_EQ   = 5'd8;
   localparam logic [4:0] S_Q_LU   = 5'd9;
   localparam logic [4:0] S_Q_LV   = 5'd10;
   localparam logic [4:0] S_Q_LC   = 5'd11;
   localparam logic [4:0] S_Q_P    = 5'd12;
   localparam logic [4:0] S_Q_PW   = 5'd13;
   localparam logic [4:0] S_Q_DL   = 5'd14;
   localparam logic [4:0] S_Q_DLW  = 5'd15;
   localparam logic [4:0] S_Q_FIN  = 5'd16;
   localparam logic [4:0] S_JUMP   = 5'd17;
   localparam logic [4:0] S_JWAIT  = 5'd18;
   localparam logic [4:0] S_OUT    = 5'd19;

   localparam tpsw_pkg::lvl_type LVL_LAST = tpsw_pkg::LVL_W'(tpsw_pkg::LIFT_LEVELS - 1);

   logic [4:0] state_ff, state_in, ret_ff, ret_in;
   tpsw_pkg::node_type a_ff, a_in, b_ff, b_in, u_ff, u_in, v_ff, v_in;
   tpsw_pkg::node_type xu_ff, xu_in, lc_ff, lc_in, mid_ff, mid_in, res_ff, res_in;
   logic [tpsw_pkg::STEPS_W-1:0] c_ff, c_in;
   tpsw_pkg::depth_type da_ff, da_in, db_ff, db_in;
   tpsw_pkg::dist_type jdist_ff, jdist_in;
   tpsw_pkg::lvl_type lvl_ff, lvl_in;
   logic jsel_ff, jsel_in;
   logic rsp_valid_ff, rsp_valid_in;
   tpsw_pkg::node_type rsp_node_ff, rsp_node_in;
   logic anc_zero_ff, dep_zero_ff;

   tpsw_pkg::node_type anc_rnode, dep_rnode, jnode, anc_q, anc_wdata, anc_wnode;
   tpsw_pkg::lvl_type anc_rlvl, anc_wlvl;
   logic anc_we, dep_we, rsp_load;
   tpsw_pkg::depth_type dep_q, dep_wdata;
   logic [tpsw_pkg::NODE_W-1:0] anc_rdata;
   logic [tpsw_pkg::DEPTH_W-1:0] dep_rdata;
   tpsw_pkg::diff_type da_s, db_s, dl_s, c_s, down1, up, c2, down2, jd_raw;

   tpsw_ram #(.WIDTH(tpsw_pkg::NODE_W), .DEPTH(2 ** tpsw_pkg::ANC_AW)) u_anc_ram (
      .clock (clock),
      .we    (anc_we),
      .waddr ({anc_wnode, anc_wlvl}),
      .wdata (anc_wdata),
      .raddr ({anc_rnode, anc_rlvl}),
      .rdata (anc_rdata)
   );

   tpsw_ram #(.WIDTH(tpsw_pkg::DEPTH_W), .DEPTH(tpsw_pkg::MAX_NODES)) u_dep_ram (
      .clock (clock),
      .we    (dep_we),
      .waddr (a_ff),
      .wdata (dep_wdata),
      .raddr (dep_rnode),
      .rdata (dep_rdata)
   );

   assign anc_q = anc_zero_ff ? '0 : anc_rdata;
   assign dep_q = dep_zero_ff ? '0 : dep_rdata;
   assign jnode = jsel_ff ? v_ff : u_ff;

   assign da_s   = tpsw_pkg::DIFF_W'(da_ff);
   assign db_s   = tpsw_pkg::DIFF_W'(db_ff);
   assign dl_s   = tpsw_pkg::DIFF_W'(dep_q);
   assign c_s    = tpsw_pkg::DIFF_W'(c_ff);
   assign down1  = db_s - da_s;
   assign up     = da_s - dl_s;
   assign c2     = c_s - up;
   assign down2  = db_s - dl_s;

   always_comb begin
      anc_rnode = u_ff;
      anc_rlvl  = lvl_ff;
      case (state_ff)
         S_AT_RD: begin
            anc_rnode = mid_ff;
            anc_rlvl  = lvl_ff - 1'b1;
         end
         S_Q_LV:  anc_rnode = v_ff;
         S_Q_P:   anc_rlvl  = '0;
         S_JUMP:  anc_rnode = jnode;
         default: anc_rnode = u_ff;
      endcase
   end

   always_comb begin
      case (state_ff)
         S_AT_DEP: dep_rnode = b_ff;
         S_Q_DA:   dep_rnode = a_ff;
         S_Q_DB:   dep_rnode = b_ff;
         default:  dep_rnode = lc_ff;
      endcase
   end

   assign anc_we    = (state_ff == S_AT_DEP) || (state_ff == S_AT_WR);
   assign anc_wnode = a_ff;
   assign anc_wlvl  = (state_ff == S_AT_DEP) ? '0 : lvl_ff;
   assign anc_wdata = (state_ff == S_AT_DEP) ? b_ff : anc_q;
   assign dep_we    = (state_ff == S_AT_DPW);
   assign dep_wdata = (dep_q == tpsw_pkg::DEPTH_MAX) ? dep_q : dep_q + 1'b1;

   assign req_chan.ready    = (state_ff == S_IDLE);
   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.result_node = rsp_node_ff;
   assign rsp_load = (state_ff == S_OUT) && (!rsp_valid_ff || rsp_chan.ready);

   always_comb begin
      state_in = state_ff;
      ret_in   = ret_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      c_in     = c_ff;
      u_in     = u_ff;
      v_in     = v_ff;
      xu_in    = xu_ff;
      lc_in    = lc_ff;
      mid_in   = mid_ff;
      res_in   = res_ff;
      da_in    = da_ff;
      db_in    = db_ff;
      jdist_in = jdist_ff;
      lvl_in   = lvl_ff;
      jsel_in  = jsel_ff;
      jd_raw   = '0;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_node_in  = rsp_node_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_node_in  = res_ff;
      end
      case (state_ff)
         S_IDLE: begin
            if (req_chan.valid) begin
               a_in = req_chan.node_a;
               b_in = req_chan.node_b;
               c_in = req_chan.steps;
               if (req_chan.action == tpsw_pkg::ACT_ATTACH) begin
                  state_in = (req_chan.node_a == '0) ? S_IDLE : S_AT_DEP;
               end else if (req_chan.node_a == req_chan.node_b) begin
                  res_in   = req_chan.node_b;
                  state_in = S_OUT;
               end else begin
                  state_in = S_Q_DA;
               end
            end
         end
         S_AT_DEP: state_in = S_AT_DPW;
         S_AT_DPW: begin
            mid_in   = b_ff;
            lvl_in   = tpsw_pkg::LVL_W'(1);
            state_in = (tpsw_pkg::LIFT_LEVELS == 1) ? S_IDLE : S_AT_RD;
         end
         S_AT_RD: state_in = S_AT_WR;
         S_AT_WR: begin
            mid_in   = anc_q;
            lvl_in   = lvl_ff + 1'b1;
            state_in = (lvl_ff == LVL_LAST) ? S_IDLE : S_AT_RD;
         end
         S_Q_DA: state_in = S_Q_DB;
         S_Q_DB: begin
            da_in    = dep_q;
            state_in = S_Q_DBW;
         end
         S_Q_DBW: begin
            db_in  = dep_q;
            u_in   = a_ff;
            v_in   = b_ff;
            lvl_in = '0;
            ret_in = S_Q_EQ;
            if (da_ff > dep_q) begin
               jsel_in  = 1'b0;
               jd_raw   = da_s - tpsw_pkg::DIFF_W'(dep_q);
               jdist_in = jd_raw[tpsw_pkg::LIFT_LEVELS-1:0];
               state_in = S_JUMP;
            end else if (dep_q > da_ff) begin
               jsel_in  = 1'b1;
               jd_raw   = tpsw_pkg::DIFF_W'(dep_q) - da_s;
               jdist_in = jd_raw[tpsw_pkg::LIFT_LEVELS-1:0];
               state_in = S_JUMP;
            end else begin
               state_in = S_Q_EQ;
            end
         end
         S_Q_EQ: begin
            lvl_in = LVL_LAST;
            if (u_ff == v_ff) begin
               lc_in    = u_ff;
               state_in = S_Q_DL;
            end else begin
               state_in = S_Q_LU;
            end
         end
         S_Q_LU: state_in = S_Q_LV;
         S_Q_LV: begin
            xu_in    = anc_q;
            state_in = S_Q_LC;
         end
         S_Q_LC: begin
            if (xu_ff != anc_q) begin
               u_in = xu_ff;
               v_in = anc_q;
            end
            lvl_in   = lvl_ff - 1'b1;
            state_in = (lvl_ff == '0) ? S_Q_P : S_Q_LU;
         end
         S_Q_P:  state_in = S_Q_PW;
         S_Q_PW: begin
            lc_in    = anc_q;
            state_in = S_Q_DL;
         end
         S_Q_DL: state_in = S_Q_DLW;
         S_Q_DLW: begin
            lvl_in   = '0;
            ret_in   = S_Q_FIN;
            state_in = S_JUMP;
            if (lc_ff == a_ff) begin
               if (down1 <= c_s) begin
                  res_in   = b_ff;
                  state_in = S_OUT;
               end else begin
                  v_in     = b_ff;
                  jsel_in  = 1'b1;
                  jd_raw   = down1 - c_s;
                  jdist_in = jd_raw[tpsw_pkg::LIFT_LEVELS-1:0];
               end
            end else if (up >= c_s) begin
               u_in     = a_ff;
               jsel_in  = 1'b0;
               jdist_in = c_s[tpsw_pkg::LIFT_LEVELS-1:0];
            end else if (down2 <= c2) begin
               res_in   = b_ff;
               state_in = S_OUT;
            end else begin
               v_in     = b_ff;
               jsel_in  = 1'b1;
               jd_raw   = down2 - c2;
               jdist_in = jd_raw[tpsw_pkg::LIFT_LEVELS-1:0];
            end
         end
         S_Q_FIN: begin
            res_in   = jnode;
            state_in = S_OUT;
         end
         S_JUMP: begin
            if (jdist_ff[lvl_ff]) begin
               state_in = S_JWAIT;
            end else if (lvl_ff == LVL_LAST) begin
               state_in = ret_ff;
            end else begin
               lvl_in = lvl_ff + 1'b1;
            end
         end
         S_JWAIT: begin
            if (jsel_ff) begin
               v_in = anc_q;
            end else begin
               u_in = anc_q;
            end
            lvl_in   = lvl_ff + 1'b1;
            state_in = (lvl_ff == LVL_LAST) ? ret_ff : S_JUMP;
         end
         S_OUT: begin
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ret_ff      <= ret_in;
      a_ff        <= a_in;
      b_ff        <= b_in;
      c_ff        <= c_in;
      u_ff        <= u_in;
      v_ff        <= v_in;
      xu_ff       <= xu_in;
      lc_ff       <= lc_in;
      mid_ff      <= mid_in;
      res_ff      <= res_in;
      da_ff       <= da_in;
      db_ff       <= db_in;
      jdist_ff    <= jdist_in;
      lvl_ff      <= lvl_in;
      jsel_ff     <= jsel_in;
      rsp_node_ff <= rsp_node_in;
      anc_zero_ff <= (anc_rnode == '0);
      dep_zero_ff <= (dep_rnode == '0);
   end

   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> (!anc_we && !dep_we))
      else $error("table write while idle");

   a_lvl_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_JUMP || state_ff == S_JWAIT) |-> (lvl_ff <= LVL_LAST))
      else $error("lifting level out of range");

   a_rsp_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_chan.ready) |=> (rsp_node_ff == $past(rsp_node_ff)))
      else $error("pending result overwritten");

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready && req_chan.action == tpsw_pkg::ACT_QUERY)
      |=> (state_ff != S_IDLE))
      else $error("query dropped");
endmodule

@@ bench/tree_path_step_walker_core_checker.sv @@
// Checker for the tree path step walker: watches both channels, predicts
// each query's node from its own ancestor and depth tables, and compares.
// Depends on tpsw_pkg and tpsw_if.
module tree_path_step_walker_core_checker (
   input  logic clock,
   input  logic reset,
   tpsw_req_if  req_chan,
   tpsw_rsp_if  rsp_chan,
   output int   fail_count,
   output int   nodes_owed
);
   tpsw_pkg::node_type  lift_rows [tpsw_pkg::MAX_NODES][tpsw_pkg::LIFT_LEVELS];
   tpsw_pkg::depth_type node_depth [tpsw_pkg::MAX_NODES];
   tpsw_pkg::node_type  owed_nodes [$];

   function automatic tpsw_pkg::node_type climb(tpsw_pkg::node_type start, int span);
      tpsw_pkg::node_type n;
      n = start;
      if (span <= 0) return n;
      for (int l = 0; l < tpsw_pkg::LIFT_LEVELS; l++)
         if ((span >> l) & 1) n = lift_rows[n][l];
      return n;
   endfunction

   function automatic tpsw_pkg::node_type meet_point(tpsw_pkg::node_type u,
                                                     tpsw_pkg::node_type v);
      int du;
      int dv;
      du = int'(node_depth[u]);
      dv = int'(node_depth[v]);
      if (du > dv) u = climb(u, du - dv);
      else if (dv > du) v = climb(v, dv - du);
      if (u == v) return u;
      for (int l = tpsw_pkg::LIFT_LEVELS - 1; l >= 0; l--)
         if (lift_rows[u][l] != lift_rows[v][l]) begin
            u = lift_rows[u][l];
            v = lift_rows[v][l];
         end
      return lift_rows[u][0];
   endfunction

   function automatic void graft(tpsw_pkg::node_type child, tpsw_pkg::node_type parent);
      int d;
      if (child == 0) return;
      lift_rows[child][0] = parent;
      d = int'(node_depth[parent]) + 1;
      node_depth[child] = (d > int'(tpsw_pkg::DEPTH_MAX)) ? tpsw_pkg::DEPTH_MAX
                                                          : tpsw_pkg::depth_type'(d);
      for (int l = 1; l < tpsw_pkg::LIFT_LEVELS; l++)
         lift_rows[child][l] = lift_rows[lift_rows[child][l-1]][l-1];
   endfunction

   function automatic tpsw_pkg::node_type walk_to(tpsw_pkg::node_type a,
                                                  tpsw_pkg::node_type b, int c);
      tpsw_pkg::node_type m;
      int da;
      int db;
      int dm;
      int up;
      int down;
      if (a == b) return b;
      m  = meet_point(a, b);
      da = int'(node_depth[a]);
      db = int'(node_depth[b]);
      dm = int'(node_depth[m]);
      if (m == a) begin
         down = db - da;
         if (down <= c) return b;
         return climb(b, down - c);
      end
      up = da - dm;
      if (up >= c) return climb(a, c);
      c = c - up;
      down = db - dm;
      if (down <= c) return b;
      return climb(b, down - c);
   endfunction

   initial begin
      fail_count = 0;
      nodes_owed = 0;
      foreach (node_depth[i]) begin
         node_depth[i] = '0;
         for (int l = 0; l < tpsw_pkg::LIFT_LEVELS; l++) lift_rows[i][l] = '0;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (owed_nodes.size() == 0) begin
               $error("result_node: none expected, actual %0d", rsp_chan.result_node);
               fail_count++;
            end else begin
               if (rsp_chan.result_node !== owed_nodes[0]) begin
                  $error("result_node: expected %0d, actual %0d",
                         owed_nodes[0], rsp_chan.result_node);
                  fail_count++;
               end
               void'(owed_nodes.pop_front());
            end
         end
         if (req_chan.valid && req_chan.ready) begin
            if (req_chan.action == tpsw_pkg::ACT_ATTACH)
               graft(req_chan.node_a, req_chan.node_b);
            else
               owed_nodes.insert(owed_nodes.size(),
                                 walk_to(req_chan.node_a, req_chan.node_b,
                                         int'(req_chan.steps)));
         end
         nodes_owed = owed_nodes.size();
      end
   end
endmodule

@@ bench/tree_path_step_walker_core_test.sv @@
// Top of the tree path step walker bench: builds trees parent first, sends
// attaches and walk queries with random gaps and stalls, and gives the verdict.
// Depends on tpsw_pkg, tpsw_if, the core and its checker.
module tree_path_step_walker_core_test;
   logic clock;
   logic reset;
   int   fail_count;
   int   nodes_owed;
   bit   steady;
   bit   placed [tpsw_pkg::MAX_NODES];
   int   placed_list [$];
   int   newest;

   tpsw_req_if req_chan ();
   tpsw_rsp_if rsp_chan ();

   tree_path_step_walker_core uut (
      .clock(clock), .reset(reset), .req_chan(req_chan), .rsp_chan(rsp_chan));

   tree_path_step_walker_core_checker watch (
      .clock(clock), .reset(reset), .req_chan(req_chan), .rsp_chan(rsp_chan),
      .fail_count(fail_count), .nodes_owed(nodes_owed));

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   initial begin
      #20000000;
      $display("tree_path_step_walker_core_test: done, errors");
      $finish;
   end

   function automatic int pause_len();
      int r;
      if (steady) return 0;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   task automatic send(logic act, int a, int b, int s);
      int g;
      g = pause_len();
      if (g > 0) begin
         req_chan.valid = 0;
         repeat (g) @(negedge clock);
      end
      req_chan.action = act;
      req_chan.node_a = tpsw_pkg::NODE_W'(a);
      req_chan.node_b = tpsw_pkg::NODE_W'(b);
      req_chan.steps  = tpsw_pkg::STEPS_W'(s);
      req_chan.valid  = 1;
      do @(posedge clock); while (!req_chan.ready);
      @(negedge clock);
   endtask

   task automatic attach(int child, int parent);
      send(tpsw_pkg::ACT_ATTACH, child, parent, int'($urandom_range(0, 2047)));
      if (child != 0 && !placed[child]) begin
         placed[child] = 1;
         placed_list.insert(placed_list.size(), child);
      end
      if (child != 0) newest = child;
   endtask

   function automatic int any_placed();
      if ($urandom_range(0, 19) == 0) return 0;
      return placed_list[$urandom_range(0, placed_list.size() - 1)];
   endfunction

   function automatic int pick_steps();
      int r;
      r = $urandom_range(0, 9);
      if (r < 4) return int'($urandom_range(0, 8));
      if (r < 8) return int'($urandom_range(0, 64));
      return int'($urandom_range(0, 2047));
   endfunction

   initial begin
      int flip;
      rsp_chan.ready = 0;
      forever begin
         @(negedge clock);
         if (steady) rsp_chan.ready = 1;
         else begin
            flip = $urandom_range(0, 99);
            if (flip < 3) begin
               rsp_chan.ready = 0;
               repeat ($urandom_range(10, 60)) @(negedge clock);
            end else rsp_chan.ready = (flip < 70);
         end
      end
   end

   initial begin
      int child;
      int parent;
      reset = 1;
      steady = 0;
      newest = 0;
      req_chan.valid = 0;
      req_chan.action = tpsw_pkg::ACT_ATTACH;
      req_chan.node_a = '0;
      req_chan.node_b = '0;
      req_chan.steps = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 0;

      attach(1, 0);
      attach(0, 1);
      attach(2, 1);
      attach(3, 2);
      attach(1023, 3);
      attach(512, 1);
      send(tpsw_pkg::ACT_QUERY, 1023, 512, 0);
      send(tpsw_pkg::ACT_QUERY, 1023, 512, 2047);
      send(tpsw_pkg::ACT_QUERY, 1023, 1023, 5);
      send(tpsw_pkg::ACT_QUERY, 1, 1023, 2);
      send(tpsw_pkg::ACT_QUERY, 1023, 1, 1);
      send(tpsw_pkg::ACT_QUERY, 512, 1023, 3);
      send(tpsw_pkg::ACT_QUERY, 0, 1023, 1);
      send(tpsw_pkg::ACT_QUERY, 1023, 0, 2047);
      attach(3, 512);
      send(tpsw_pkg::ACT_QUERY, 1023, 2, 1);
      send(tpsw_pkg::ACT_QUERY, 3, 2, 1);

      for (int i = 0; i < 1900; i++) begin
         if (i % 300 == 150) steady = ~steady;
         if ($urandom_range(0, 99) < 35) begin
            parent = ($urandom_range(0, 1) == 0) ? newest : any_placed();
            if (placed_list.size() < tpsw_pkg::MAX_NODES - 1 && $urandom_range(0, 9) != 0)
            begin
               do child = int'($urandom_range(1, tpsw_pkg::MAX_NODES - 1));
               while (placed[child]);
            end else if ($urandom_range(0, 19) == 0) child = 0;
            else child = placed_list[$urandom_range(0, placed_list.size() - 1)];
            attach(child, parent);
         end else begin
            child = any_placed();
            parent = ($urandom_range(0, 19) == 0) ? child : any_placed();
            send(tpsw_pkg::ACT_QUERY, child, parent, pick_steps());
         end
      end
      req_chan.valid = 0;
      steady = 0;

      while (nodes_owed != 0) @(posedge clock);
      repeat (150) @(posedge clock);
      if (fail_count == 0)
         $display("tree_path_step_walker_core_test: done, clean");
      else
         $display("tree_path_step_walker_core_test: done, errors");
      $finish;
   end
endmodule

@@ sim.f @@
rtl/tpsw_pkg.sv
rtl/tpsw_if.sv
rtl/tpsw_ram.sv
rtl/tree_path_step_walker_core.sv
bench/tree_path_step_walker_core_checker.sv
bench/tree_path_step_walker_core_test.sv
